/* hw/rtl/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the command frame builder
// Beat payload types, the queue entry and the frame constants.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam logic [15:0] CRC_POLY       = 16'h8005;
   localparam logic [7:0]  WORD_ADDRESS   = 8'h03;
   localparam logic [7:0]  COUNT_OVERHEAD = 8'd3;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] payload_length;
      logic       first_item;
      logic       last_item;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

   // one classified payload beat waiting for the back end
   typedef struct packed {
      logic [7:0]  data;
      logic [7:0]  count;
      logic [15:0] crc;
      logic        first;
      logic        last;
   } job_type;

endpackage

/* hw/rtl/crc16_command_frame_builder_core.sv */
// ----------------------------------------------------------------------------
// crc16_command_frame_builder_core: command frame builder with crc-16 (0x8005)
// path: a req beat taken is written into the job queue, then into the output
//   register, from which its first rsp beat is offered
// throughput: 1 req beat per cycle while the 4-entry job queue has room
// output: 1 rsp beat per cycle from the output register while rsp_ready is high,
//   so an item gives 1 rsp beat, plus 2 on a first beat, plus 2 on a last beat
// reset: synchronous, clears crc to zero, empties the queue, drops rsp_valid
// ----------------------------------------------------------------------------
module crc16_command_frame_builder_core
   import cfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // front to queue
   logic    push;
   job_type push_job;
   logic    queue_full;

   // queue to back
   logic    pop;
   job_type head;
   logic    queue_empty;

   // front: take a beat, fold the payload (after the count on a first beat) into the running crc
   cfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_job    (push_job),
      .queue_full  (queue_full)
   );

   // queue: lets a long frame tail drain while new beats keep arriving
   cfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty)
   );

   // back: word address, count, payload, crc low then crc high
   cfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/cfb_front.sv */
// ----------------------------------------------------------------------------
// cfb_front: input side of the command frame builder
// Accepts payload beats, runs the crc and pushes one job per beat.
// ----------------------------------------------------------------------------
module cfb_front
   import cfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    push,
   output job_type push_job,
   input  logic    queue_full
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] crc_base;
   logic [7:0]  count;

   // lsb-first bytewise update, no reflection
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        top;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         top = c[15];
         c   = {c[14:0], 1'b0};
         if (b[i] != top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      count    = req_payload.payload_length + COUNT_OVERHEAD;
      // a first beat restarts the crc from zero with the count byte
      crc_base = req_payload.first_item ? crc_byte(16'h0000, count) : crc_ff;
      crc_in   = crc_byte(crc_base, req_payload.payload_byte);
   end

   always_comb begin
      push_job.data  = req_payload.payload_byte;
      push_job.count = count;
      push_job.crc   = crc_in;
      push_job.first = req_payload.first_item;
      push_job.last  = req_payload.last_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 16'h0000;
      end else if (push) begin
         crc_ff <= crc_in;
      end
   end

endmodule

/* hw/rtl/cfb_queue.sv */
// ----------------------------------------------------------------------------
// cfb_queue: job queue between front and back
// Small register fifo; the head is read directly by the back end.
// ----------------------------------------------------------------------------
module cfb_queue
   import cfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type                mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff;
   logic [QUEUE_AW-1:0]    rd_ptr_ff;
   logic [QUEUE_AW:0]      count_ff;
   logic [QUEUE_AW:0]      count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue pop while empty");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_AW-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

/* hw/rtl/cfb_back.sv */
// ----------------------------------------------------------------------------
// cfb_back: output side of the command frame builder
// Expands each queued job into its frame bytes through an output register.
// ----------------------------------------------------------------------------
module cfb_back
   import cfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type head,
   input  logic    empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      PH_ADDR,
      PH_COUNT,
      PH_DATA,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   phase_type phase_ff;
   phase_type phase_in;
   phase_type cur_phase;
   logic      started_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   beat;
   logic      out_free;
   logic      load;
   logic      job_done;

   assign cur_phase = started_ff ? phase_ff : (head.first ? PH_ADDR : PH_DATA);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = !empty && out_free;
   assign pop       = load && job_done;

   always_comb begin
      beat.frame_end = 1'b0;
      phase_in       = PH_DATA;
      job_done       = 1'b0;
      case (cur_phase)
         PH_ADDR: begin
            beat.frame_byte = WORD_ADDRESS;
            phase_in        = PH_COUNT;
         end
         PH_COUNT: begin
            beat.frame_byte = head.count;
            phase_in        = PH_DATA;
         end
         PH_DATA: begin
            beat.frame_byte = head.data;
            phase_in        = PH_CRC_LO;
            job_done        = !head.last;
         end
         PH_CRC_LO: begin
            beat.frame_byte = head.crc[7:0];
            phase_in        = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            beat.frame_byte = head.crc[15:8];
            beat.frame_end  = 1'b1;
            job_done        = 1'b1;
         end
         default: begin
            beat.frame_byte = head.data;
            job_done        = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         phase_ff     <= PH_ADDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            started_ff   <= !job_done;
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_ff <= beat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_end_pops: assert property (@(posedge clock) disable iff (reset)
      load && beat.frame_end |-> pop)
      else $error("frame end beat did not retire its job");

   a_started_has_job: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> !empty)
      else $error("mid-job phase with an empty queue");

   a_crc_hi_after_lo: assert property (@(posedge clock) disable iff (reset)
      load && cur_phase == PH_CRC_HI |-> started_ff && phase_ff == PH_CRC_HI)
      else $error("crc high byte without crc low byte");

endmodule

/* tb/frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker: scoreboard for the command frame builder
// Watches both channels, rebuilds the outgoing frame bytes and the crc-16 of
// every accepted payload beat, and compares each accepted frame byte in order.
// ----------------------------------------------------------------------------
module frame_checker
   import cfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatch_count,
   output int      outstanding_bytes,
   output int      checked_bytes
);

   rsp_type     expected_frame_bytes[$];
   logic [15:0] crc_shadow = '0;
   int          errors = 0;
   int          checked = 0;

   // crc-16, poly 0x8005, data bits taken lsb first
   function automatic logic [15:0] crc16_fold_byte(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (data[i] != c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic rsp_type frame_entry(logic [7:0] data, logic last);
      rsp_type e;
      e.frame_byte = data;
      e.frame_end  = last;
      return e;
   endfunction

   task automatic queue_frame_bytes(req_type beat);
      logic [7:0] count;
      if (beat.first_item) begin
         count = beat.payload_length + COUNT_OVERHEAD;
         expected_frame_bytes.push_back(frame_entry(WORD_ADDRESS, 1'b0));
         expected_frame_bytes.push_back(frame_entry(count, 1'b0));
         crc_shadow = crc16_fold_byte(16'h0000, count);
      end
      expected_frame_bytes.push_back(frame_entry(beat.payload_byte, 1'b0));
      crc_shadow = crc16_fold_byte(crc_shadow, beat.payload_byte);
      if (beat.last_item) begin
         expected_frame_bytes.push_back(frame_entry(crc_shadow[7:0], 1'b0));
         expected_frame_bytes.push_back(frame_entry(crc_shadow[15:8], 1'b1));
      end
   endtask

   always @(posedge clock) begin : compare_beats
      rsp_type want;
      if (reset) begin
         expected_frame_bytes.delete();
         crc_shadow = '0;
      end else begin
         // results first: a result can never come from a beat taken this edge
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_frame_bytes.size() == 0) begin
               errors++;
               $display("%0t: frame byte %h end %b with nothing expected",
                        $realtime, rsp_payload.frame_byte, rsp_payload.frame_end);
            end else begin
               want = expected_frame_bytes.pop_front();
               if (rsp_payload.frame_byte !== want.frame_byte) begin
                  errors++;
                  $display("%0t: frame_byte expected %h actual %h",
                           $realtime, want.frame_byte, rsp_payload.frame_byte);
               end
               if (rsp_payload.frame_end !== want.frame_end) begin
                  errors++;
                  $display("%0t: frame_end expected %b actual %b",
                           $realtime, want.frame_end, rsp_payload.frame_end);
               end
            end
         end
         if (req_valid && req_ready) begin
            queue_frame_bytes(req_payload);
         end
      end
      mismatch_count    <= errors;
      outstanding_bytes <= expected_frame_bytes.size();
      checked_bytes     <= checked;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the command frame builder
// Drives directed and random payload beats under several idle patterns, with
// a long receiver hold-off and drain pauses; frame_checker scores the output.
// ----------------------------------------------------------------------------
module testbench;
   import cfb_pkg::*;

   localparam int HOLD_CYCLES    = 60;    // long receiver hold-off, fills the job queue
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat before giving up
   localparam int DRAIN_CYCLES   = 10;    // idle wait after the final drain, before the verdict
   localparam int RANDOM_BEATS   = 200;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int mismatch_count;
   int outstanding_bytes;
   int checked_bytes;

   // idle pattern of the current phase, in percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // hold-off requests: the stimulus bumps hold_req, the receiver counts the cycles
   int hold_req  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int beats_sent     = 0;
   int frames_started = 0;
   int idle_cycles    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   crc16_command_frame_builder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   frame_checker frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .mismatch_count    (mismatch_count),
      .outstanding_bytes (outstanding_bytes),
      .checked_bytes     (checked_bytes)
   );

   // receiver side: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: any beat on either channel restarts the count
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
      end
      $display("%0t: no beat moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
   end

   // one payload beat; random idle cycles first, then hold valid until taken
   task automatic send_beat(logic [7:0] data, logic [7:0] len, logic first, logic last);
      req_type beat;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      beat.payload_byte   = data;
      beat.payload_length = len;
      beat.first_item     = first;
      beat.last_item      = last;
      req_payload <= beat;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      beats_sent = beats_sent + 1;
      if (first) begin
         frames_started = frames_started + 1;
      end
   endtask

   // a frame of n_bytes; the length field only counts on the first beat
   task automatic send_frame(int n_bytes, logic [7:0] len_field, bit close);
      for (int i = 0; i < n_bytes; i++) begin
         send_beat(8'($urandom_range(255)),
                   (i == 0) ? len_field : 8'($urandom_range(255)),
                   (i == 0), close && (i == n_bytes - 1));
      end
   endtask

   // sender pause until every expected frame byte has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding_bytes != 0);
   endtask

   initial begin : stimulus
      int target;
      int pick;
      int n;
      bit held;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      send_beat(8'hA5, 8'h00, 1'b0, 1'b0);   // stray byte right after reset
      send_beat(8'h00, 8'd1,  1'b1, 1'b1);   // one-byte frame
      send_beat(8'hFF, 8'd255, 1'b1, 1'b1);  // length wraps the count byte
      send_beat(8'h5A, 8'd77, 1'b0, 1'b0);   // stray byte after a frame, crc carries on
      send_beat(8'h80, 8'd0,  1'b1, 1'b0);   // length zero, three bytes sent
      send_beat(8'h01, 8'hFF, 1'b0, 1'b0);
      send_beat(8'h7F, 8'h00, 1'b0, 1'b1);
      send_beat(8'hC3, 8'd252, 1'b1, 1'b0); // top legal length, short frame
      send_beat(8'h3C, 8'hAA, 1'b0, 1'b1);
      send_beat(8'h12, 8'd253, 1'b1, 1'b1);
      send_beat(8'h34, 8'd254, 1'b1, 1'b1);
      send_beat(8'h9E, 8'h55, 1'b0, 1'b1);  // last beat with no first
      send_beat(8'h11, 8'd4,  1'b1, 1'b0);  // frame restarted before its last beat
      send_beat(8'h22, 8'h0F, 1'b0, 1'b0);
      send_beat(8'h33, 8'd2,  1'b1, 1'b0);
      send_beat(8'h44, 8'hF0, 1'b0, 1'b1);
      send_beat(8'hFE, 8'd128, 1'b1, 1'b0);
      send_beat(8'h01, 8'h00, 1'b0, 1'b1);
      send_beat(8'hAA, 8'd2,  1'b1, 1'b0);  // well-formed two-byte frame
      send_beat(8'h55, 8'h00, 1'b0, 1'b1);
      wait_for_drain();

      // random part in four idle phases
      target = beats_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         target = target + RANDOM_BEATS / 4;
         held = 1'b0;
         while (beats_sent < target) begin
            // long hold-off while the sender keeps offering beats
            if (!held && (phase == 0 || phase == 3) && beats_sent + 35 > target) begin
               hold_req <= hold_req + 1;
               held = 1'b1;
            end
            pick = $urandom_range(99);
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (pick < 80) begin
               send_frame(n, 8'(n), 1'b1);
            end else if (pick < 88) begin
               send_frame(n, 8'($urandom_range(255)), 1'b1);   // length field off
            end else if (pick < 93) begin
               send_frame(n, 8'(n), 1'b0);                     // never closed
            end else if (pick < 97) begin
               send_beat(8'($urandom_range(255)), 8'($urandom_range(255)),
                         1'b0, 1'($urandom_range(1)));         // stray beat
            end else begin
               wait_for_drain();
            end
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d payload beats, %0d frames opened, %0d frame bytes checked",
               beats_sent, frames_started, checked_bytes);
      $display("summary: idle phases none/sender/receiver/both, %0d receiver hold-offs",
               hold_req);
      if (mismatch_count == 0 && outstanding_bytes == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/cfb_pkg.sv
hw/rtl/cfb_front.sv
hw/rtl/cfb_queue.sv
hw/rtl/cfb_back.sv
hw/rtl/crc16_command_frame_builder_core.sv
tb/frame_checker.sv
tb/testbench.sv
